// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared widths, operation codes and defaults for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int unsigned FRAC_DEFAULT = 16;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned KIND_W = 4;
   localparam int unsigned EXP_W = 5;
   localparam int unsigned REQ_TDATA_W = 104;
   localparam int unsigned RSP_TDATA_W = 40;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type K_ADD      = 4'd0;
   localparam kind_type K_SUB      = 4'd1;
   localparam kind_type K_NEG      = 4'd2;
   localparam kind_type K_MUL      = 4'd3;
   localparam kind_type K_DIV      = 4'd4;
   localparam kind_type K_MUL_INT  = 4'd5;
   localparam kind_type K_DIV_INT  = 4'd6;
   localparam kind_type K_COMPARE  = 4'd7;
   localparam kind_type K_ABS      = 4'd8;
   localparam kind_type K_MIN      = 4'd9;
   localparam kind_type K_MAX      = 4'd10;
   localparam kind_type K_POW      = 4'd11;
   localparam kind_type K_FROM_INT = 4'd12;
   localparam kind_type K_TO_INT   = 4'd13;
   localparam kind_type K_PASS     = 4'd14;

endpackage

// File: rtl/fixed_point_alu.sv
// Simple operations, a zero divisor and pow with exponent zero go from idle straight to
// S_DONE. Mul and mul_int pass S_MUL and S_MACC on the shared 32x32 multiplier; pow
// repeats S_MUL and S_MACC once per exponent count; div and div_int run the 32 restoring
// division steps in S_DIV, then S_DFIN. One transaction is in work at a time; the next is
// taken in the cycle after the result moves to the output register. Synchronous
// active-high reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit fixed-point ALU built around one shared multiplier and one
// bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
   parameter int unsigned FRAC = fpa_pkg::FRAC_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // operand_a[31:0], operand_b[63:32], int_operand[95:64], exponent[100:96]
   input  logic [fpa_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // kind[3:0]
   input  fpa_pkg::kind_type                    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result[31:0], is_less[32], is_equal[33], is_greater[34], div_zero[35]
   output logic [fpa_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int unsigned QSHIFT = FRAC / 4;
   localparam int unsigned HSHIFT = FRAC / 2;
   localparam logic [31:0] FX_ONE = 32'd1 << FRAC;
   localparam logic [31:0] POW_START = 32'd1 << (FRAC - QSHIFT);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_MACC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DFIN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]                      state_ff, state_in;
   fpa_pkg::kind_type               kind_ff, kind_in;
   logic [31:0]                     opx_ff, opx_in;
   logic [31:0]                     opy_ff, opy_in;
   logic [31:0]                     prod_ff, prod_in;
   logic [31:0]                     res_ff, res_in;
   logic [31:0]                     quo_ff, quo_in;
   logic [31:0]                     rem_ff, rem_in;
   logic [31:0]                     den_ff, den_in;
   logic                            neg_ff, neg_in;
   logic [4:0]                      cnt_ff, cnt_in;
   logic                            dz_ff, dz_in;
   logic                            lt_ff, lt_in;
   logic                            eq_ff, eq_in;
   logic                            gt_ff, gt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fpa_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0] a_v, b_v, n_v;
   logic [4:0]  e_v;
   logic        a_lt_b, a_gt_b;
   logic [31:0] simple_res;
   logic [31:0] div_num, div_den, num_mag, den_mag;
   logic [32:0] rem_shift;
   logic        rem_ge;
   logic [31:0] post_mul;
   logic [31:0] quo_signed;

   assign a_v = req_tdata[31:0];
   assign b_v = req_tdata[63:32];
   assign n_v = req_tdata[95:64];
   assign e_v = req_tdata[100:96];

   assign a_lt_b = $signed(a_v) < $signed(b_v);
   assign a_gt_b = $signed(a_v) > $signed(b_v);

   always_comb begin
      case (req_tuser)
         fpa_pkg::K_ADD:      simple_res = a_v + b_v;
         fpa_pkg::K_SUB:      simple_res = a_v - b_v;
         fpa_pkg::K_NEG:      simple_res = 32'd0 - a_v;
         fpa_pkg::K_COMPARE:  simple_res = 32'd0;
         fpa_pkg::K_ABS:      simple_res = a_v[31] ? (32'd0 - a_v) : a_v;
         fpa_pkg::K_MIN:      simple_res = a_gt_b ? b_v : a_v;
         fpa_pkg::K_MAX:      simple_res = a_lt_b ? b_v : a_v;
         fpa_pkg::K_FROM_INT: simple_res = n_v << FRAC;
         fpa_pkg::K_TO_INT:   simple_res = $signed(a_v) >>> FRAC;
         default:             simple_res = a_v;
      endcase
   end

   assign div_num = (req_tuser == fpa_pkg::K_DIV) ? (a_v << QSHIFT) : a_v;
   assign div_den = (req_tuser == fpa_pkg::K_DIV) ? 32'($signed(b_v) >>> QSHIFT) : n_v;
   assign num_mag = div_num[31] ? (32'd0 - div_num) : div_num;
   assign den_mag = div_den[31] ? (32'd0 - div_den) : div_den;

   assign rem_shift = {rem_ff, quo_ff[31]};
   assign rem_ge = rem_shift >= {1'b0, den_ff};
   assign post_mul = (kind_ff == fpa_pkg::K_MUL_INT) ? prod_ff
                                                     : 32'($signed(prod_ff) >>> HSHIFT);
   assign quo_signed = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      opx_in = opx_ff;
      opy_in = opy_ff;
      prod_in = prod_ff;
      res_in = res_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      dz_in = dz_ff;
      lt_in = lt_ff;
      eq_in = eq_ff;
      gt_in = gt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               lt_in = a_lt_b;
               eq_in = a_v == b_v;
               gt_in = a_gt_b;
               dz_in = 1'b0;
               cnt_in = 5'd0;
               case (req_tuser)
                  fpa_pkg::K_MUL: begin
                     opx_in = $signed(a_v) >>> QSHIFT;
                     opy_in = $signed(b_v) >>> QSHIFT;
                     state_in = S_MUL;
                  end
                  fpa_pkg::K_MUL_INT: begin
                     opx_in = a_v;
                     opy_in = n_v;
                     state_in = S_MUL;
                  end
                  fpa_pkg::K_POW: begin
                     if (e_v == 5'd0) begin
                        res_in = FX_ONE;
                        state_in = S_DONE;
                     end else begin
                        opx_in = POW_START;
                        opy_in = $signed(a_v) >>> QSHIFT;
                        cnt_in = e_v;
                        state_in = S_MUL;
                     end
                  end
                  fpa_pkg::K_DIV, fpa_pkg::K_DIV_INT: begin
                     if (div_den == 32'd0) begin
                        res_in = 32'd0;
                        dz_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        quo_in = num_mag;
                        rem_in = 32'd0;
                        den_in = den_mag;
                        neg_in = div_num[31] ^ div_den[31];
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     res_in = simple_res;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in = opx_ff * opy_ff;
            state_in = S_MACC;
         end
         S_MACC: begin
            if (kind_ff == fpa_pkg::K_POW && cnt_ff != 5'd1) begin
               opx_in = $signed(post_mul) >>> QSHIFT;
               cnt_in = cnt_ff - 5'd1;
               state_in = S_MUL;
            end else begin
               res_in = post_mul;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (rem_ge) begin
               rem_in = 32'(rem_shift - {1'b0, den_ff});
            end else begin
               rem_in = rem_shift[31:0];
            end
            quo_in = {quo_ff[30:0], rem_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            res_in = (kind_ff == fpa_pkg::K_DIV) ? (quo_signed << HSHIFT) : quo_signed;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'd0, dz_ff, gt_ff, eq_ff, lt_ff, res_ff};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      opx_ff <= opx_in;
      opy_ff <= opy_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      dz_ff <= dz_in;
      lt_ff <= lt_in;
      eq_ff <= eq_in;
      gt_ff <= gt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tdata[34:32]))
      else $error("Comparison flags are not exactly one hot.");

   a_dz_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[35]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("Divide by zero transaction carries a nonzero result.");

   a_dz_div_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && dz_ff) |->
         (kind_ff == fpa_pkg::K_DIV || kind_ff == fpa_pkg::K_DIV_INT))
      else $error("Divide by zero flag raised for a non-divide operation.");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff != 5'd31) |=> (state_ff == S_DIV))
      else $error("Division left its step loop early.");
`endif

endmodule
